// ===== hdl/iqm_pkg.sv =====
// Shared constants, register codes and types of the interquartile mean filter.
package iqm_pkg;

	localparam int IQM_MAX_SAMPLES = 64;

	localparam int SampleW   = 24;
	localparam int DiscardW  = 8;
	localparam int CountRegW = 7;
	localparam int CfgDataW  = 8;
	localparam int CfgIdxW   = 1;

	localparam logic [CfgIdxW-1:0] REG_DISCARD = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_COUNT   = 1'b1;

	localparam logic [DiscardW-1:0]  DISCARD_RST = 8'd0;
	localparam logic [CountRegW-1:0] COUNT_RST   = 7'd16;

	typedef struct packed {
		logic q_empty;
		logic back_busy;
	} iqm_stat_t;

endpackage

// ===== hdl/interquartile_mean_filter.sv =====
// Top level of the interquartile mean filter: front end, command queue and back end.
// A sample is taken at a rising edge with start high and busy low. Discarded samples at
// the head of a batch are taken one per cycle at all times. A kept sample is taken
// while the sample store is free; once the last sample of a batch is in, busy stays high
// for kept samples while each stored sample is ranked against all others through the
// single read port of the store and a one-bit-per-cycle divider then forms the mean. The
// mean appears on mean, and stays there until the next result, with done high for
// exactly one cycle; the receiver cannot stall it.
module interquartile_mean_filter
	import iqm_pkg::*;
#(
	parameter int MAX_SAMPLES = IQM_MAX_SAMPLES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [SampleW-1:0] sample,
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data,
	output logic                      done,
	output logic signed [SampleW-1:0] mean
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = $clog2(MAX_SAMPLES);

	iqm_stat_t          stat;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [SampleW-1:0] wr_data;
	logic               push;
	logic [CW-1:0]      push_count;
	logic               pop;
	logic [CW-1:0]      cmd_count;
	logic               q_empty;
	logic               q_full;
	logic               back_busy;

	assign stat.q_empty   = q_empty;
	assign stat.back_busy = back_busy;

	iqm_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (sample),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_count(push_count)
	);

	iqm_queue #(
		.W(CW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_count),
		.pop   (pop),
		.dout  (cmd_count),
		.empty (q_empty),
		.full  (q_full)
	);

	iqm_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.cmd_valid(!q_empty),
		.cmd_count(cmd_count),
		.pop      (pop),
		.back_busy(back_busy),
		.done     (done),
		.mean     (mean)
	);

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("Batch completed while the command queue was full.");

endmodule

// ===== hdl/iqm_front.sv =====
// Front end: configuration registers, batch counting and sample store writes.
module iqm_front
	import iqm_pkg::*;
#(
	parameter int MAX_SAMPLES = IQM_MAX_SAMPLES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SampleW-1:0]      sample,
	output logic                           busy,
	input  logic                           cfg_we,
	input  logic [CfgIdxW-1:0]             cfg_index,
	input  logic [CfgDataW-1:0]            cfg_data,
	input  iqm_stat_t                      stat,
	output logic                           wr_en,
	output logic [$clog2(MAX_SAMPLES)-1:0] wr_addr,
	output logic [SampleW-1:0]             wr_data,
	output logic                           push,
	output logic [$clog2(MAX_SAMPLES+1)-1:0] push_count
);

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int IW   = $clog2(MAX_SAMPLES);
	localparam int PosW = $clog2(256 + MAX_SAMPLES);

	logic [DiscardW-1:0]  discard_q;
	logic [CountRegW-1:0] count_q;
	logic [PosW-1:0]      pos_q;
	logic [DiscardW-1:0]  act_disc_q;
	logic [CW-1:0]        act_cnt_q;

	logic                 at_start;
	logic [CW-1:0]        cfg_cnt;
	logic [DiscardW-1:0]  eff_disc;
	logic [CW-1:0]        eff_cnt;
	logic                 discarding;
	logic [PosW-1:0]      k;
	logic [PosW-1:0]      kc;
	logic                 last;
	logic                 accept;

	always_comb begin
		at_start = (pos_q == '0);
		if (count_q == '0) begin
			cfg_cnt = CW'(1);
		end else if (int'(count_q) > MAX_SAMPLES) begin
			cfg_cnt = CW'(MAX_SAMPLES);
		end else begin
			cfg_cnt = CW'(count_q);
		end
		eff_disc   = at_start ? discard_q : act_disc_q;
		eff_cnt    = at_start ? cfg_cnt : act_cnt_q;
		discarding = (pos_q < PosW'(eff_disc));
		k          = pos_q - PosW'(eff_disc);
		kc         = (k >= PosW'(eff_cnt)) ? PosW'(eff_cnt - CW'(1)) : k;
		last       = (k >= PosW'(eff_cnt - CW'(1)));
		busy       = !discarding && !(stat.q_empty && !stat.back_busy);
		accept     = start && !busy;
	end

	assign wr_en      = accept && !discarding;
	assign wr_addr    = kc[IW-1:0];
	assign wr_data    = sample;
	assign push       = accept && !discarding && last;
	assign push_count = eff_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q  <= DISCARD_RST;
			count_q    <= COUNT_RST;
			pos_q      <= '0;
			act_disc_q <= DISCARD_RST;
			act_cnt_q  <= CW'(COUNT_RST);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DISCARD: discard_q <= cfg_data;
					REG_COUNT:   count_q   <= cfg_data[CountRegW-1:0];
					default:     discard_q <= discard_q;
				endcase
			end
			if (accept) begin
				if (at_start) begin
					act_disc_q <= discard_q;
					act_cnt_q  <= cfg_cnt;
				end
				if (!discarding && last) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + PosW'(1);
				end
			end
		end
	end

endmodule

// ===== hdl/iqm_queue.sv =====
// Two-entry queue of batch commands between the front end and the back end.
module iqm_queue #(
	parameter int W = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] data_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign dout  = data_q[rp_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("Command pushed into a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("Command popped from an empty queue.");

endmodule

// ===== hdl/iqm_back.sv =====
// Back end: sample store, rank-based middle-half sum and signed divider.
module iqm_back
	import iqm_pkg::*;
#(
	parameter int MAX_SAMPLES = IQM_MAX_SAMPLES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [$clog2(MAX_SAMPLES)-1:0]   wr_addr,
	input  logic [SampleW-1:0]               wr_data,
	input  logic                             cmd_valid,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0] cmd_count,
	output logic                             pop,
	output logic                             back_busy,
	output logic                             done,
	output logic signed [SampleW-1:0]        mean
);

	localparam int CW      = $clog2(MAX_SAMPLES + 1);
	localparam int IW      = $clog2(MAX_SAMPLES);
	localparam int AccW    = SampleW + $clog2(MAX_SAMPLES);
	localparam int DivCntW = $clog2(AccW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_KEYW,
		S_SCAN,
		S_ACC,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

	state_t                    state_q;
	logic [SampleW-1:0]        store_q [MAX_SAMPLES];
	logic signed [SampleW-1:0] rd_data_q;
	logic [IW-1:0]             rd_addr;
	logic [CW-1:0]             n_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic [CW-1:0]             m_q;
	logic [CW-1:0]             i_q;
	logic [CW-1:0]             j_q;
	logic [CW-1:0]             jd_q;
	logic [CW-1:0]             rank_q;
	logic signed [SampleW-1:0] key_q;
	logic signed [AccW-1:0]    acc_q;
	logic [AccW-1:0]           dvd_q;
	logic [CW-1:0]             rem_q;
	logic                      neg_q;
	logic [DivCntW-1:0]        dcnt_q;
	logic signed [SampleW-1:0] mean_q;
	logic                      done_q;

	logic [CW-1:0]             lo_c;
	logic                      less;
	logic [AccW-1:0]           acc_abs;
	logic [CW:0]               rem_sh;
	logic                      ge;
	logic [CW:0]               rem_sub;
	logic [SampleW-1:0]        quo;

	always_comb begin
		lo_c    = cmd_count >> 2;
		less    = (rd_data_q < key_q) || ((rd_data_q == key_q) && (jd_q < i_q));
		acc_abs = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
		rem_sh  = {rem_q, dvd_q[AccW-1]};
		ge      = (rem_sh >= {1'b0, m_q});
		rem_sub = rem_sh - {1'b0, m_q};
		quo     = dvd_q[SampleW-1:0];
		case (state_q)
			S_KEY:   rd_addr = i_q[IW-1:0];
			S_SCAN:  rd_addr = j_q[IW-1:0];
			default: rd_addr = '0;
		endcase
	end

	assign pop       = (state_q == S_IDLE) && cmd_valid;
	assign back_busy = (state_q != S_IDLE);
	assign done      = done_q;
	assign mean      = mean_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						n_q     <= cmd_count;
						lo_q    <= lo_c;
						hi_q    <= cmd_count - lo_c;
						m_q     <= cmd_count - (lo_c << 1);
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					state_q <= S_KEYW;
				end
				S_KEYW: begin
					key_q   <= rd_data_q;
					rank_q  <= '0;
					jd_q    <= '0;
					j_q     <= CW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					rank_q <= rank_q + CW'(less);
					jd_q   <= j_q;
					j_q    <= j_q + CW'(1);
					if (jd_q == n_q - CW'(1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if ((rank_q >= lo_q) && (rank_q < hi_q)) begin
						acc_q <= acc_q + AccW'(key_q);
					end
					if (i_q == n_q - CW'(1)) begin
						state_q <= S_PREP;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_KEY;
					end
				end
				S_PREP: begin
					neg_q   <= acc_q[AccW-1];
					dvd_q   <= acc_abs;
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
					dvd_q  <= {dvd_q[AccW-2:0], ge};
					dcnt_q <= dcnt_q + DivCntW'(1);
					if (dcnt_q == DivCntW'(AccW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					mean_q  <= neg_q ? -quo : quo;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_IDLE)
		else $error("Sample store written while a batch is being ranked.");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> jd_q < n_q)
		else $error("Rank scan ran past the batch size.");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FIN))
		else $error("Mean strobed without a finished division.");

endmodule
